>>> rtl/wgf_pkg.sv
`default_nettype none
package wgf_pkg;

	localparam int MAX_DIM         = 32;
	localparam int MAX_HALF_EXTENT = 4;
	localparam int COEF_DEPTH      = 49;
	localparam int DIM_W           = $clog2(MAX_DIM);
	localparam int VOX_DEPTH       = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int VOX_AW          = 3 * DIM_W;
	localparam int COEF_AW         = $clog2(COEF_DEPTH);
	localparam int NUM_W           = 56;
	localparam int DEN_W           = 40;

	localparam logic [15:0] Q_ONE = 16'h8000;

	localparam logic [1:0] OP_WRITE_VOXEL = 2'd0;
	localparam logic [1:0] OP_WRITE_COEF  = 2'd1;
	localparam logic [1:0] OP_FILTER      = 2'd2;

	localparam logic [2:0] REG_DIM_X       = 3'd0;
	localparam logic [2:0] REG_DIM_Y       = 3'd1;
	localparam logic [2:0] REG_DIM_Z       = 3'd2;
	localparam logic [2:0] REG_RADIUS_SQ   = 3'd3;
	localparam logic [2:0] REG_HALF_EXTENT = 3'd4;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [4:0]         pos_x;
		logic [4:0]         pos_y;
		logic [4:0]         pos_z;
		logic signed [15:0] sample;
		logic [15:0]        weight;
		logic [5:0]         dist_index;
		logic [15:0]        coefficient;
	} in_t;

	typedef struct packed {
		logic signed [15:0] filtered;
		logic               sum_was_zero;
	} out_t;

endpackage
`default_nettype wire

>>> rtl/wgf_ram.sv
`default_nettype none
module wgf_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/wgf_divider.sv
`default_nettype none
module wgf_divider (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [wgf_pkg::NUM_W-1:0]  num,
	input  wire logic        [wgf_pkg::DEN_W-1:0]  den,
	output logic                                   done,
	output wgf_pkg::out_t                          res
);

	localparam int NW = wgf_pkg::NUM_W;
	localparam int DW = wgf_pkg::DEN_W;
	localparam int CW = $clog2(NW);

	logic          run_q, fin_q, zero_q, neg_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	wgf_pkg::out_t res_q;

	logic [DW:0]   shifted;
	logic          ge;
	logic [NW-1:0] mag;

	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign mag     = num[NW-1] ? NW'(-num) : NW'(num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				fin_q <= (den == '0);
				run_q <= (den != '0);
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (den == '0);
			neg_q  <= num[NW-1];
			den_q  <= den;
			rem_q  <= '0;
			quo_q  <= mag;
		end else if (run_q) begin
			rem_q <= ge ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[NW-2:0], ge};
		end
		if (fin_q) begin
			res_q.sum_was_zero <= zero_q;
			// truncated magnitude, then sign and clamp to 16 bits
			if (zero_q) begin
				res_q.filtered <= '0;
			end else if (neg_q) begin
				res_q.filtered <= (quo_q > NW'(32768)) ? 16'sh8000 : 16'(-quo_q[15:0]);
			end else begin
				res_q.filtered <= (quo_q > NW'(32767)) ? 16'sh7fff : 16'(quo_q[15:0]);
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

>>> rtl/weighted_gaussian_filter_3d.sv
// Write requests (voxel, coefficient) are taken while idle; busy stays low.
// Filter request: a scan over the (2h+1)^3 neighbours, h = min(half_extent, 4),
// then a pipeline drain, the divider's shift-subtract steps (none for a zero weight sum)
// and its finish state before the result; the scan is set by the single read port of the
// voxel memory, one read a cycle. Results show for one cycle on res_valid; the
// receiver cannot stall. Reset sets control and configuration to defaults; memories are undefined.
`default_nettype none
module weighted_gaussian_filter_3d (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire wgf_pkg::in_t  req,
	output logic               res_valid,
	output wgf_pkg::out_t      res,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [5:0]    cfg_data
);

	localparam int AW = wgf_pkg::VOX_AW;
	localparam int CA = wgf_pkg::COEF_AW;
	localparam int DW = wgf_pkg::DIM_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DIV   = 2'd3;

	// configuration registers
	logic [5:0] dim_x_q, dim_y_q, dim_z_q, radius_q;
	logic [2:0] half_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q  <= 6'd32;
			dim_y_q  <= 6'd32;
			dim_z_q  <= 6'd32;
			radius_q <= 6'd4;
			half_q   <= 3'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wgf_pkg::REG_DIM_X:       dim_x_q  <= cfg_data;
				wgf_pkg::REG_DIM_Y:       dim_y_q  <= cfg_data;
				wgf_pkg::REG_DIM_Z:       dim_z_q  <= cfg_data;
				wgf_pkg::REG_RADIUS_SQ:   radius_q <= cfg_data;
				wgf_pkg::REG_HALF_EXTENT: half_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// effective extents: zero acts as one, clamp at the memory size
	function automatic logic [5:0] eff_dim(input logic [5:0] d);
		if (d == 6'd0) begin
			return 6'd1;
		end else if (d > 6'(wgf_pkg::MAX_DIM)) begin
			return 6'(wgf_pkg::MAX_DIM);
		end
		return d;
	endfunction

	logic [5:0] ex, ey, ez;
	assign ex = eff_dim(dim_x_q);
	assign ey = eff_dim(dim_y_q);
	assign ez = eff_dim(dim_z_q);

	logic accept;
	assign accept = start && !busy;

	// write path: requests land in the memories at the accept edge
	logic          vox_we, coef_we;
	logic [AW-1:0] vox_waddr;
	assign vox_we = accept && req.opcode == wgf_pkg::OP_WRITE_VOXEL &&
		{1'b0, req.pos_x} < ex && {1'b0, req.pos_y} < ey && {1'b0, req.pos_z} < ez;
	assign vox_waddr = {req.pos_z, req.pos_y, req.pos_x};
	assign coef_we = accept && req.opcode == wgf_pkg::OP_WRITE_COEF &&
		req.dist_index < 6'(wgf_pkg::COEF_DEPTH);

	// scan sequencer
	logic [1:0]        state_q;
	logic [4:0]        px_q, py_q, pz_q;
	logic signed [3:0] dx_q, dy_q, dz_q, hs_q;
	logic [1:0]        drain_q;
	logic              div_start;

	assign busy = state_q != ST_IDLE;

	logic [2:0] h_eff;
	assign h_eff = (half_q > 3'(wgf_pkg::MAX_HALF_EXTENT)) ?
		3'(wgf_pkg::MAX_HALF_EXTENT) : half_q;

	logic last_pt;
	assign last_pt = dx_q == hs_q && dy_q == hs_q && dz_q == hs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			dz_q    <= '0;
			hs_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && req.opcode == wgf_pkg::OP_FILTER) begin
						hs_q    <= $signed({1'b0, h_eff});
						dx_q    <= -$signed({1'b0, h_eff});
						dy_q    <= -$signed({1'b0, h_eff});
						dz_q    <= -$signed({1'b0, h_eff});
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance x fastest, then y, then z
					if (last_pt) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else if (dx_q != hs_q) begin
						dx_q <= dx_q + 4'sd1;
					end else begin
						dx_q <= -hs_q;
						if (dy_q != hs_q) begin
							dy_q <= dy_q + 4'sd1;
						end else begin
							dy_q <= -hs_q;
							dz_q <= dz_q + 4'sd1;
						end
					end
				end
				ST_DRAIN: begin
					// hold until the last neighbour has landed in the sums
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd3) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (res_valid) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign div_start = state_q == ST_DRAIN && drain_q == 2'd3;

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= req.pos_x;
			py_q <= req.pos_y;
			pz_q <= req.pos_z;
		end
	end

	// neighbour address and mask test
	logic signed [6:0] nx, ny, nz;
	logic [5:0]        d2;
	logic              nb_ok;
	assign nx = $signed({2'b0, px_q}) + 7'(dx_q);
	assign ny = $signed({2'b0, py_q}) + 7'(dy_q);
	assign nz = $signed({2'b0, pz_q}) + 7'(dz_q);
	assign d2 = 6'(7'(dx_q) * 7'(dx_q)) + 6'(7'(dy_q) * 7'(dy_q)) +
		6'(7'(dz_q) * 7'(dz_q));
	assign nb_ok = state_q == ST_SCAN && d2 <= radius_q &&
		d2 < 6'(wgf_pkg::COEF_DEPTH) &&
		!nx[6] && !ny[6] && !nz[6] &&
		nx[5:0] < ex && ny[5:0] < ey && nz[5:0] < ez;

	logic [31:0] vox_rd;
	logic [15:0] coef_rd;

	wgf_ram #(.DEPTH(wgf_pkg::VOX_DEPTH), .WIDTH(32)) u_vox (
		.clk     (clk),
		.wr_en   (vox_we),
		.wr_addr (vox_waddr),
		.wr_data ({req.sample, req.weight}),
		.rd_en   (nb_ok),
		.rd_addr ({nz[DW-1:0], ny[DW-1:0], nx[DW-1:0]}),
		.rd_data (vox_rd)
	);

	wgf_ram #(.DEPTH(wgf_pkg::COEF_DEPTH), .WIDTH(16)) u_coef (
		.clk     (clk),
		.wr_en   (coef_we),
		.wr_addr (req.dist_index[CA-1:0]),
		.wr_data (req.coefficient),
		.rd_en   (nb_ok),
		.rd_addr (d2[CA-1:0]),
		.rd_data (coef_rd)
	);

	// accumulate pipeline: read, weight product, sample product, sum
	logic               v_s1, v_s2, v_s3;
	logic [15:0]        w_sat, cf_sat;
	logic [30:0]        c_s2, c_s3;
	logic signed [15:0] smp_s2;
	logic signed [47:0] prod_s3;
	logic signed [wgf_pkg::NUM_W-1:0] num_q;
	logic [wgf_pkg::DEN_W-1:0]        den_q;

	assign w_sat  = (vox_rd[15:0] > wgf_pkg::Q_ONE) ? wgf_pkg::Q_ONE : vox_rd[15:0];
	assign cf_sat = (coef_rd > wgf_pkg::Q_ONE) ? wgf_pkg::Q_ONE : coef_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= nb_ok;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		c_s2    <= 31'(32'(wgf_pkg::Q_ONE - w_sat) * 32'(cf_sat));
		smp_s2  <= $signed(vox_rd[31:16]);
		c_s3    <= c_s2;
		prod_s3 <= $signed({1'b0, c_s2}) * smp_s2;
		// clear sums when any request is taken
		if (accept) begin
			num_q <= '0;
			den_q <= '0;
		end else if (v_s3) begin
			num_q <= num_q + wgf_pkg::NUM_W'(prod_s3);
			den_q <= den_q + wgf_pkg::DEN_W'(c_s3);
		end
	end

	wgf_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (res_valid),
		.res    (res)
	);

`ifndef SYNTHESIS
	a_res_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> state_q == ST_DIV) else $error("result outside divide phase");
	a_res_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid) else $error("result strobe longer than one cycle");
	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.sum_was_zero |-> res.filtered == 16'sd0)
		else $error("zero weight sum with nonzero result");
	a_filter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.opcode == wgf_pkg::OP_FILTER |=> busy)
		else $error("filter request did not raise busy");
`endif

endmodule
`default_nettype wire
